FILE: rtl/assert_macros.svh
// assertion helpers, all sampled on the rising edge of clk and off while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ACE_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ACE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/ace_pkg.sv
`timescale 1ns / 1ps

package ace_pkg;

    // channel count and field widths
    localparam int CHANNELS   = 8;
    localparam int CH_W       = 3;
    localparam int SAMPLE_W   = 16;
    localparam int THR_W      = 16;
    localparam int SLOPE_W    = 16;
    localparam int COEFF_W    = 17;
    localparam int CFG_DATA_W = 17;
    localparam int CFG_IDX_W  = 2;

    // shared multiplier operand width
    localparam int MUL_W = 32;

    // log2 result: 4 integer bits, 16 fraction bits
    localparam int LOG_FRAC_W = 16;
    localparam int LOG_W      = 20;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD = 2'd0,
        CFG_SLOPE     = 2'd1,
        CFG_ATTACK    = 2'd2,
        CFG_RELEASE   = 2'd3
    } cfg_reg_t;

    // register reset values
    localparam logic [THR_W-1:0]   THRESHOLD_RST = 16'd32768;
    localparam logic [SLOPE_W-1:0] SLOPE_RST     = 16'd4096;
    localparam logic [COEFF_W-1:0] ATTACK_RST    = 17'd25760;
    localparam logic [COEFF_W-1:0] RELEASE_RST   = 17'd25;

    // fixed-point unity values
    localparam logic [COEFF_W-1:0] ONE_Q16   = 17'd65536;
    localparam logic [SLOPE_W-1:0] SLOPE_ONE = 16'd4096;

    // cubic exp2 polynomial coefficients, q0.16
    localparam logic [15:0] EXP_C1 = 16'd45580;
    localparam logic [15:0] EXP_C2 = 16'd14847;
    localparam logic [15:0] EXP_C3 = 16'd5113;

endpackage

FILE: rtl/audio_compressor_expander_core.sv
// Per-channel compressor/expander for signed q1.15 audio. Each input beat carries one sample
// and its channel; the block updates that channel's peak envelope with the attack and release
// coefficients and, while the new envelope is above the threshold, scales the sample by
// (envelope/threshold)^(slope-1), computed as exp2 of a scaled log2 difference. All arithmetic
// runs through a single 32x32 multiplier under a small sequencer, so one sample is in flight
// at a time: a sample whose envelope stays at or below the threshold goes from ST_ENV_MUL
// through ST_ENV_ADD and ST_LOG_INIT to ST_DONE, a gain-scaled sample runs on through the
// two 16-round squaring log2 evaluations (envelope, then threshold) on the shared multiplier
// and the exp2 and gain steps. The input side opens in the cycle after the result is loaded.
// A result that finds the output register still occupied holds the sequencer until that
// beat is taken; once loaded, the output register lets the next sample be accepted while
// its result still waits to be taken. Configuration writes are registered and must be
// issued only while no sample is in flight.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module audio_compressor_expander_core
    import ace_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,

    // configuration write port
    input  logic                         cfg_we,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data,

    // input beat
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [SAMPLE_W-1:0]   sample_in,
    input  logic [CH_W-1:0]              channel_in,

    // output beat
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [SAMPLE_W-1:0]   sample_out,
    output logic [CH_W-1:0]              channel_out,
    output logic                         saturated
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ENV_MUL,     // env * (1 - release)
        ST_ENV_ADD,     // + excess * attack, write envelope
        ST_LOG_INIT,    // threshold compare, normalize log2 operand
        ST_LOG_SQ,      // one squaring round per cycle
        ST_DIFF,        // log2 env - log2 thr
        ST_SCALE,       // |slope-1| * |diff|
        ST_YCALC,       // signed floor shift
        ST_EXP1,
        ST_EXP2,
        ST_EXP3,
        ST_GAIN,        // |x| * 2^frac
        ST_ROUND,       // shift by integer part, round, clip
        ST_DONE         // hand result to output register
    } state_t;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [THR_W-1:0]   threshold_reg;
    logic [SLOPE_W-1:0] slope_reg;
    logic [COEFF_W-1:0] attack_reg;
    logic [COEFF_W-1:0] release_reg;

    // ------------------------------------------------------------------
    // sequencer and datapath registers
    // ------------------------------------------------------------------
    state_t                state_reg,    state_next;
    logic [3:0]            cnt_reg,      cnt_next;
    logic                  thr_pass_reg, thr_pass_next;   // log2 pass is on the threshold
    logic [15:0]           envelope_reg [CHANNELS];
    logic [SAMPLE_W-1:0]   raw_reg,      raw_next;
    logic [CH_W-1:0]       ch_reg,       ch_next;
    logic [15:0]           env_reg,      env_next;
    logic [15:0]           alpha_reg,    alpha_next;
    logic [35:0]           acc_reg,      acc_next;
    logic [15:0]           ne_reg,       ne_next;
    logic [30:0]           m_reg,        m_next;
    logic [3:0]            top_reg,      top_next;
    logic [LOG_FRAC_W-1:0] frac_reg,     frac_next;
    logic [LOG_W-1:0]      lenv_reg,     lenv_next;
    logic [LOG_W-1:0]      lthr_reg,     lthr_next;
    logic [LOG_W-1:0]      dmag_reg,     dmag_next;
    logic                  dneg_reg,     dneg_next;
    logic signed [24:0]    y_reg,        y_next;
    logic [16:0]           t_reg,        t_next;
    logic [33:0]           prod_reg,     prod_next;
    logic [SAMPLE_W-1:0]   res_reg,      res_next;
    logic                  sat_reg,      sat_next;
    logic                  env_we;

    // output register
    logic                  out_valid_reg,   out_valid_next;
    logic [SAMPLE_W-1:0]   sample_out_reg,  sample_out_next;
    logic [CH_W-1:0]       channel_out_reg, channel_out_next;
    logic                  saturated_reg,   saturated_next;

    // ------------------------------------------------------------------
    // shared multiplier
    // ------------------------------------------------------------------
    logic [MUL_W-1:0]   mul_a;
    logic [MUL_W-1:0]   mul_b;
    logic [2*MUL_W-1:0] product;

    assign product = mul_a * mul_b;

    // ------------------------------------------------------------------
    // helpers
    // ------------------------------------------------------------------
    function automatic logic [3:0] top_of(input logic [15:0] v);
        logic [3:0] t;
        t = '0;
        for (int i = 0; i < 16; i++)
        begin
            if (v[i])
            begin
                t = 4'(i);
            end
        end
        return t;
    endfunction

    logic [16:0]        mag;
    logic [THR_W-1:0]   thr_eff;
    logic [COEFF_W-1:0] ac;
    logic [COEFF_W-1:0] rc;
    logic [COEFF_W-1:0] rc_inv;
    logic [16:0]        s_diff;
    logic               s_neg;
    logic [15:0]        s_mag;
    logic [15:0]        log_src;
    logic [3:0]         src_top;
    logic [30:0]        src_m;
    logic [31:0]        sq;
    logic               sq_bit;
    logic [34:0]        env_sum;
    logic [15:0]        ne_val;
    logic [20:0]        ldiff;
    logic               p_neg;
    logic [36:0]        p_up;
    logic signed [24:0] y_val;
    logic [15:0]        f;
    logic signed [8:0]  k;
    logic signed [9:0]  sh;
    logic [5:0]         shamt;
    logic [34:0]        half;
    logic [34:0]        rnd;
    logic [34:0]        q;
    logic               chan_ok;

    // sample magnitude, 0..32768
    assign mag     = raw_reg[SAMPLE_W-1] ? 17'(17'h10000 - {1'b0, raw_reg}) : {1'b0, raw_reg};
    // a zero threshold behaves as one lsb
    assign thr_eff = (threshold_reg == '0) ? 16'd1 : threshold_reg;
    // coefficients above unity clamp to unity
    assign ac      = (attack_reg > ONE_Q16) ? ONE_Q16 : attack_reg;
    assign rc      = (release_reg > ONE_Q16) ? ONE_Q16 : release_reg;
    assign rc_inv  = ONE_Q16 - rc;
    // slope - 1 in sign/magnitude
    assign s_diff  = {1'b0, slope_reg} - {1'b0, SLOPE_ONE};
    assign s_neg   = s_diff[16];
    assign s_mag   = s_neg ? 16'(-s_diff) : s_diff[15:0];

    // log2 operand normalization: mantissa in [2^30, 2^31)
    assign log_src = thr_pass_reg ? thr_eff : ne_reg;
    assign src_top = top_of(log_src);
    assign src_m   = 31'(log_src) << (5'd30 - {1'b0, src_top});

    // squaring round: renormalize when the square reaches 2.0
    assign sq      = product[61:30];
    assign sq_bit  = sq[31];

    // envelope update sum, saturated to 16 bits after the q16 shift
    assign env_sum = 35'(acc_reg[33:0]) + 35'(product[33:0]);
    assign ne_val  = (|env_sum[34:32]) ? 16'hFFFF : env_sum[31:16];

    assign ldiff   = {1'b0, lenv_reg} - {1'b0, lthr_reg};

    // floor((slope-1) * diff / 4096) from the unsigned product in acc_reg
    assign p_neg   = s_neg ^ dneg_reg;
    assign p_up    = 37'(acc_reg) + 37'd4095;
    assign y_val   = p_neg ? -$signed(p_up[36:12]) : $signed({1'b0, acc_reg[35:12]});

    // exponent split: integer part k, fraction f
    assign f       = y_reg[15:0];
    assign k       = y_reg[24:16];
    assign sh      = 10'sd16 - 10'(k);
    assign shamt   = sh[5:0];
    assign half    = 35'd1 << (shamt - 6'd1);
    assign rnd     = 35'(prod_reg) + half;

    always_comb
    begin
        priority if (prod_reg == '0)
        begin
            q = '0;
        end
        else if (sh <= 10'sd0)
        begin
            q = 35'h10000;            // forces saturation
        end
        else if (sh >= 10'sd33)
        begin
            q = '0;
        end
        else
        begin
            q = rnd >> shamt;
        end
    end

    assign chan_ok = (32'(channel_in) < CHANNELS);

    // ------------------------------------------------------------------
    // multiplier operand selection
    // ------------------------------------------------------------------
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_ENV_MUL:
            begin
                mul_a = 32'(env_reg);
                mul_b = 32'(rc_inv);
            end
            ST_ENV_ADD:
            begin
                mul_a = 32'(alpha_reg);
                mul_b = 32'(ac);
            end
            ST_LOG_SQ:
            begin
                mul_a = 32'(m_reg);
                mul_b = 32'(m_reg);
            end
            ST_SCALE:
            begin
                mul_a = 32'(s_mag);
                mul_b = 32'(dmag_reg);
            end
            ST_EXP1:
            begin
                mul_a = 32'(f);
                mul_b = 32'(EXP_C3);
            end
            ST_EXP2:
            begin
                mul_a = 32'(f);
                mul_b = 32'(EXP_C2) + 32'(t_reg);
            end
            ST_EXP3:
            begin
                mul_a = 32'(f);
                mul_b = 32'(EXP_C1) + 32'(t_reg);
            end
            ST_GAIN:
            begin
                mul_a = 32'(mag);
                mul_b = 32'(ONE_Q16) + 32'(t_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        thr_pass_next    = thr_pass_reg;
        raw_next         = raw_reg;
        ch_next          = ch_reg;
        env_next         = env_reg;
        alpha_next       = alpha_reg;
        acc_next         = acc_reg;
        ne_next          = ne_reg;
        m_next           = m_reg;
        top_next         = top_reg;
        frac_next        = frac_reg;
        lenv_next        = lenv_reg;
        lthr_next        = lthr_reg;
        dmag_next        = dmag_reg;
        dneg_next        = dneg_reg;
        y_next           = y_reg;
        t_next           = t_reg;
        prod_next        = prod_reg;
        res_next         = res_reg;
        sat_next         = sat_reg;
        env_we           = 1'b0;
        // output beat leaves when taken
        out_valid_next   = out_valid_reg && !out_ready;
        sample_out_next  = sample_out_reg;
        channel_out_next = channel_out_reg;
        saturated_next   = saturated_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    raw_next      = sample_in;
                    ch_next       = channel_in;
                    env_next      = envelope_reg[channel_in];
                    thr_pass_next = 1'b0;
                    if (chan_ok)
                    begin
                        state_next = ST_ENV_MUL;
                    end
                    else
                    begin
                        // unknown channel: pass through untouched
                        res_next   = sample_in;
                        sat_next   = 1'b0;
                        state_next = ST_DONE;
                    end
                end
            end
            ST_ENV_MUL:
            begin
                acc_next   = 36'(product[33:0]);
                alpha_next = (mag > {1'b0, env_reg}) ? 16'(mag - {1'b0, env_reg}) : '0;
                state_next = ST_ENV_ADD;
            end
            ST_ENV_ADD:
            begin
                ne_next    = ne_val;
                env_we     = 1'b1;
                state_next = ST_LOG_INIT;
            end
            ST_LOG_INIT:
            begin
                if (!thr_pass_reg && !(ne_reg > thr_eff))
                begin
                    // at or below threshold: unity gain
                    res_next   = raw_reg;
                    sat_next   = 1'b0;
                    state_next = ST_DONE;
                end
                else
                begin
                    m_next     = src_m;
                    top_next   = src_top;
                    frac_next  = '0;
                    cnt_next   = '0;
                    state_next = ST_LOG_SQ;
                end
            end
            ST_LOG_SQ:
            begin
                m_next    = sq_bit ? sq[31:1] : sq[30:0];
                frac_next = {frac_reg[LOG_FRAC_W-2:0], sq_bit};
                cnt_next  = cnt_reg + 4'd1;
                if (cnt_reg == 4'd15)
                begin
                    if (thr_pass_reg)
                    begin
                        lthr_next  = {top_reg, frac_next};
                        state_next = ST_DIFF;
                    end
                    else
                    begin
                        lenv_next     = {top_reg, frac_next};
                        thr_pass_next = 1'b1;
                        state_next    = ST_LOG_INIT;
                    end
                end
            end
            ST_DIFF:
            begin
                dneg_next  = ldiff[20];
                dmag_next  = ldiff[20] ? 20'(-ldiff) : ldiff[19:0];
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                acc_next   = product[35:0];
                state_next = ST_YCALC;
            end
            ST_YCALC:
            begin
                y_next     = y_val;
                state_next = ST_EXP1;
            end
            ST_EXP1:
            begin
                t_next     = product[32:16];
                state_next = ST_EXP2;
            end
            ST_EXP2:
            begin
                t_next     = product[32:16];
                state_next = ST_EXP3;
            end
            ST_EXP3:
            begin
                t_next     = product[32:16];
                state_next = ST_GAIN;
            end
            ST_GAIN:
            begin
                prod_next  = product[33:0];
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                if (!raw_reg[SAMPLE_W-1])
                begin
                    if (q > 35'd32767)
                    begin
                        res_next = 16'h7FFF;
                        sat_next = 1'b1;
                    end
                    else
                    begin
                        res_next = q[15:0];
                        sat_next = 1'b0;
                    end
                end
                else
                begin
                    if (q > 35'd32768)
                    begin
                        res_next = 16'h8000;
                        sat_next = 1'b1;
                    end
                    else
                    begin
                        res_next = 16'(17'h10000 - q[16:0]);
                        sat_next = 1'b0;
                    end
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next   = 1'b1;
                    sample_out_next  = res_reg;
                    channel_out_next = ch_reg;
                    saturated_next   = sat_reg;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // state, datapath, envelopes, configuration and output register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            cnt_reg         <= '0;
            thr_pass_reg    <= 1'b0;
            threshold_reg   <= THRESHOLD_RST;
            slope_reg       <= SLOPE_RST;
            attack_reg      <= ATTACK_RST;
            release_reg     <= RELEASE_RST;
            for (int i = 0; i < CHANNELS; i++)
            begin
                envelope_reg[i] <= '0;
            end
            raw_reg         <= '0;
            ch_reg          <= '0;
            env_reg         <= '0;
            alpha_reg       <= '0;
            acc_reg         <= '0;
            ne_reg          <= '0;
            m_reg           <= '0;
            top_reg         <= '0;
            frac_reg        <= '0;
            lenv_reg        <= '0;
            lthr_reg        <= '0;
            dmag_reg        <= '0;
            dneg_reg        <= 1'b0;
            y_reg           <= '0;
            t_reg           <= '0;
            prod_reg        <= '0;
            res_reg         <= '0;
            sat_reg         <= 1'b0;
            out_valid_reg   <= 1'b0;
            sample_out_reg  <= '0;
            channel_out_reg <= '0;
            saturated_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            cnt_reg         <= cnt_next;
            thr_pass_reg    <= thr_pass_next;
            raw_reg         <= raw_next;
            ch_reg          <= ch_next;
            env_reg         <= env_next;
            alpha_reg       <= alpha_next;
            acc_reg         <= acc_next;
            ne_reg          <= ne_next;
            m_reg           <= m_next;
            top_reg         <= top_next;
            frac_reg        <= frac_next;
            lenv_reg        <= lenv_next;
            lthr_reg        <= lthr_next;
            dmag_reg        <= dmag_next;
            dneg_reg        <= dneg_next;
            y_reg           <= y_next;
            t_reg           <= t_next;
            prod_reg        <= prod_next;
            res_reg         <= res_next;
            sat_reg         <= sat_next;
            out_valid_reg   <= out_valid_next;
            sample_out_reg  <= sample_out_next;
            channel_out_reg <= channel_out_next;
            saturated_reg   <= saturated_next;

            if (env_we)
            begin
                envelope_reg[ch_reg] <= ne_val;
            end

            if (cfg_we)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    CFG_THRESHOLD: threshold_reg <= cfg_data[THR_W-1:0];
                    CFG_SLOPE:     slope_reg     <= cfg_data[SLOPE_W-1:0];
                    CFG_ATTACK:    attack_reg    <= cfg_data[COEFF_W-1:0];
                    CFG_RELEASE:   release_reg   <= cfg_data[COEFF_W-1:0];
                endcase
            end
        end
    end

    assign in_ready    = (state_reg == ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign sample_out  = sample_out_reg;
    assign channel_out = channel_out_reg;
    assign saturated   = saturated_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // one sample in flight: the input side is closed in the cycle after a beat is accepted
    `ACE_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready, "second beat accepted")
    // squaring log2 keeps its mantissa normalized in [1.0, 2.0)
    `ACE_ASSERT_IMPLY(a_log_norm, state_reg == ST_LOG_SQ, m_reg[30], "log2 mantissa lost")
    // a clipped result sits on one of the rails
    `ACE_ASSERT_IMPLY(a_sat_rail, out_valid && saturated,
        sample_out == 16'h7FFF || sample_out == 16'h8000, "saturated beat off the rail")
    // the log2 round counter only runs while squaring
    `ACE_ASSERT_IMPLY(a_cnt_idle, state_reg == ST_IDLE, !(state_next == ST_LOG_SQ),
        "squaring entered from idle")

endmodule

FILE: verif/audio_compressor_expander_core_test.sv
`timescale 1ns / 1ps

module audio_compressor_expander_core_test;
    import ace_pkg::*;

    // cycles the sender sits idle before a config write once the block has drained
    localparam int SETTLE_CYCLES = 8;
    // longest sample path to the output register is the gain-scaled one
    localparam int TAIL_CYCLES   = 60;
    localparam int SAMPLE_ITEMS  = 1300;
    localparam int MAX_WAIT      = 18;
    localparam int PRINT_CAP     = 200;

    typedef enum logic [1:0]
    {
        FEED_SAMPLE,
        FEED_CONFIG,
        FEED_DRAIN
    } feed_kind_t;

    // one entry of the sender's work list
    typedef struct
    {
        feed_kind_t                  kind;
        logic signed [SAMPLE_W-1:0]  sample;
        logic [CH_W-1:0]             channel;
        cfg_reg_t                    reg_sel;
        logic [CFG_DATA_W-1:0]       value;
        int                          gap;
    } feed_entry_t;

    // one output beat as the block should produce it
    typedef struct
    {
        logic signed [SAMPLE_W-1:0]  sample;
        logic [CH_W-1:0]             channel;
        logic                        clipped;
    } scaled_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         cfg_we = 1'b0;
    cfg_reg_t                     cfg_index = CFG_THRESHOLD;
    logic [CFG_DATA_W-1:0]        cfg_data = '0;
    logic                         in_valid = 1'b0;
    logic                         in_ready;
    logic signed [SAMPLE_W-1:0]   sample_in = '0;
    logic [CH_W-1:0]              channel_in = '0;
    logic                         out_valid;
    logic                         out_ready = 1'b0;
    logic signed [SAMPLE_W-1:0]   sample_out;
    logic [CH_W-1:0]              channel_out;
    logic                         saturated;

    audio_compressor_expander_core dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .sample_in   (sample_in),
        .channel_in  (channel_in),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .sample_out  (sample_out),
        .channel_out (channel_out),
        .saturated   (saturated)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // shadow of the register file and the per-channel peak envelopes
    logic [THR_W-1:0]     thr_cfg     = THRESHOLD_RST;
    logic [SLOPE_W-1:0]   slope_cfg   = SLOPE_RST;
    logic [COEFF_W-1:0]   attack_cfg  = ATTACK_RST;
    logic [COEFF_W-1:0]   release_cfg = RELEASE_RST;
    logic [15:0]          env_q [0:CHANNELS-1] = '{default: '0};

    feed_entry_t  feed_q[$];
    scaled_t      pending_scaled[$];

    int  mismatches = 0;
    int  sample_total = 0;
    bit  sender_calm = 1'b0;
    int  gap_count = 0;
    int  settle_count = 0;
    int  rx_stall = 0;
    int  results_seen = 0;
    bit  rx_calm = 1'b0;

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("mismatch at %0t: %s", $realtime, what);
    endtask

    // log2 in q4.16: top set bit plus 16 rounds of squaring a q1.30 mantissa
    function automatic logic [LOG_W-1:0] log2_fixed(input logic [15:0] v);
        logic [15:0]  w;
        logic [63:0]  m;
        logic [15:0]  frac;
        int           top;
        int           i;
        w = (v == 16'd0) ? 16'd1 : v;
        top = 15;
        while (top > 0 && !w[top])
            top--;
        m = {48'd0, w} << (30 - top);
        frac = '0;
        for (i = 0; i < 16; i++)
        begin
            m = (m * m) >> 30;
            frac = {frac[14:0], 1'b0};
            if (m >= 64'h8000_0000)
            begin
                frac[0] = 1'b1;
                m = m >> 1;
            end
        end
        return {4'(top), frac};
    endfunction

    // cubic exp2 of a q0.16 fraction, result q1.16
    function automatic logic [63:0] exp2_fraction(input logic [63:0] f);
        logic [63:0] t;
        t = (f * EXP_C3) >> 16;
        t = (f * (EXP_C2 + t)) >> 16;
        t = (f * (EXP_C1 + t)) >> 16;
        return 64'(ONE_Q16) + t;
    endfunction

    // envelope update and gain scaling of one sample
    function automatic scaled_t scale_sample(input logic signed [SAMPLE_W-1:0] x,
                                             input logic [CH_W-1:0] ch);
        scaled_t      r;
        logic         neg;
        logic [63:0]  mag;
        logic [63:0]  env;
        logic [63:0]  alpha;
        logic [63:0]  ac;
        logic [63:0]  rc;
        logic [63:0]  nxt_env;
        logic [63:0]  thr;
        logic [63:0]  f;
        logic [63:0]  prod;
        logic [63:0]  q;
        longint       d;
        longint       s;
        longint       y;
        longint       k;
        longint       sh;
        neg = x[SAMPLE_W-1];
        mag = neg ? 64'd65536 - {48'd0, x} : {48'd0, x};
        r.sample = x;
        r.channel = ch;
        r.clipped = 1'b0;

        // coefficients above one act as one
        ac = (attack_cfg > ONE_Q16) ? 64'(ONE_Q16) : {47'd0, attack_cfg};
        rc = (release_cfg > ONE_Q16) ? 64'(ONE_Q16) : {47'd0, release_cfg};
        env = {48'd0, env_q[ch]};
        alpha = (mag > env) ? mag - env : 64'd0;
        nxt_env = (env * (64'(ONE_Q16) - rc) + alpha * ac) >> 16;
        if (nxt_env > 64'hFFFF)
            nxt_env = 64'hFFFF;
        env_q[ch] = nxt_env[15:0];

        // zero threshold behaves as the smallest nonzero one
        thr = (thr_cfg == '0) ? 64'd1 : {48'd0, thr_cfg};

        if (nxt_env > thr)
        begin
            d = longint'({44'd0, log2_fixed(nxt_env[15:0])})
                - longint'({44'd0, log2_fixed(thr[15:0])});
            s = longint'({48'd0, slope_cfg}) - longint'({48'd0, SLOPE_ONE});
            y = (s * d) >>> 12;
            k = y >>> 16;
            f = 64'(y - k * 65536);
            prod = mag * exp2_fraction(f);
            sh = 16 - k;
            if (prod == 64'd0)
                q = 64'd0;
            else if (sh <= 0)
                q = 64'h10000;
            else if (sh >= 64)
                q = 64'd0;
            else
                q = (prod + (64'd1 << (sh - 1))) >> sh;

            if (!neg)
            begin
                if (q > 64'd32767)
                begin
                    q = 64'd32767;
                    r.clipped = 1'b1;
                end
                r.sample = q[15:0];
            end
            else
            begin
                if (q > 64'd32768)
                begin
                    q = 64'd32768;
                    r.clipped = 1'b1;
                end
                r.sample = 16'(64'h10000 - q);
            end
        end
        return r;
    endfunction

    // per-item idle draw, with calm stretches that never idle
    function automatic int draw_wait(input bit calm);
        if (calm)
            return 0;
        return $urandom_range(0, MAX_WAIT);
    endfunction

    task automatic push_sample(input logic signed [SAMPLE_W-1:0] s, input logic [CH_W-1:0] ch);
        feed_entry_t e;
        e = '{kind: FEED_SAMPLE, sample: s, channel: ch, reg_sel: CFG_THRESHOLD,
              value: '0, gap: draw_wait(sender_calm)};
        feed_q.push_back(e);
        sample_total++;
    endtask

    task automatic push_config(input cfg_reg_t sel, input logic [CFG_DATA_W-1:0] v);
        feed_entry_t e;
        e = '{kind: FEED_CONFIG, sample: '0, channel: '0, reg_sel: sel, value: v, gap: 0};
        feed_q.push_back(e);
    endtask

    // sender holds off until every scaled beat has come back
    task automatic push_drain();
        feed_entry_t e;
        e = '{kind: FEED_DRAIN, sample: '0, channel: '0, reg_sel: CFG_THRESHOLD,
              value: '0, gap: 0};
        feed_q.push_back(e);
    endtask

    function automatic logic [15:0] pick_threshold();
        case ($urandom_range(0, 9))
            0: return 16'd0;
            1: return 16'd1;
            2: return 16'd32768;
            3: return 16'($urandom_range(32769, 65535));
            default: return 16'($urandom_range(64, 16384));
        endcase
    endfunction

    function automatic logic [15:0] pick_slope();
        case ($urandom_range(0, 9))
            0: return 16'd0;
            1: return 16'd65535;
            2: return SLOPE_ONE;
            3: return 16'($urandom_range(0, 65535));
            default: return 16'($urandom_range(512, 12288));
        endcase
    endfunction

    function automatic logic [COEFF_W-1:0] pick_coeff();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return ONE_Q16;
            2: return COEFF_W'($urandom_range(65537, 131071));
            3: return COEFF_W'(131071);
            default: return COEFF_W'($urandom_range(1, 65535));
        endcase
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        logic signed [SAMPLE_W-1:0] v;
        case ($urandom_range(0, 9))
            0, 1: v = SAMPLE_W'($urandom_range(0, 65535));
            2:
            begin
                case ($urandom_range(0, 4))
                    0: v = 16'sh7FFF;
                    1: v = 16'sh8000;
                    2: v = 16'sh0000;
                    3: v = 16'shFFFF;
                    default: v = 16'sh0001;
                endcase
            end
            3: v = SAMPLE_W'($urandom_range(0, 511)) - 16'sd256;
            default:
            begin
                // loud passages push the envelope past the threshold
                v = SAMPLE_W'($urandom_range(8192, 32767));
                if ($urandom_range(0, 1) == 1)
                    v = -v;
            end
        endcase
        return v;
    endfunction

    // sender: beats, register writes and drain points in list order
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            cfg_we   <= 1'b0;
            gap_count = 0;
            settle_count = 0;
        end
        else
        begin
            // the prediction is made at the edge where the beat is taken
            if (in_valid && in_ready)
                pending_scaled.push_back(scale_sample(sample_in, channel_in));

            if (in_valid && !in_ready)
            begin
                // beat held with its payload until taken
                cfg_we <= 1'b0;
            end
            else if (feed_q.size() == 0)
            begin
                in_valid <= 1'b0;
                cfg_we   <= 1'b0;
            end
            else if (feed_q[0].kind == FEED_DRAIN)
            begin
                in_valid <= 1'b0;
                cfg_we   <= 1'b0;
                if (pending_scaled.size() == 0 && !out_valid)
                    settle_count++;
                else
                    settle_count = 0;
                if (settle_count >= SETTLE_CYCLES)
                begin
                    settle_count = 0;
                    feed_q.delete(0);
                end
            end
            else if (feed_q[0].kind == FEED_CONFIG)
            begin
                // block is idle here, shadow copy moves with the write
                in_valid  <= 1'b0;
                cfg_we    <= 1'b1;
                cfg_index <= feed_q[0].reg_sel;
                cfg_data  <= feed_q[0].value;
                case (feed_q[0].reg_sel)
                    CFG_THRESHOLD: thr_cfg     = feed_q[0].value[THR_W-1:0];
                    CFG_SLOPE:     slope_cfg   = feed_q[0].value[SLOPE_W-1:0];
                    CFG_ATTACK:    attack_cfg  = feed_q[0].value[COEFF_W-1:0];
                    CFG_RELEASE:   release_cfg = feed_q[0].value[COEFF_W-1:0];
                endcase
                feed_q.delete(0);
            end
            else if (gap_count >= feed_q[0].gap)
            begin
                // valid stays up across back-to-back beats
                in_valid   <= 1'b1;
                cfg_we     <= 1'b0;
                sample_in  <= feed_q[0].sample;
                channel_in <= feed_q[0].channel;
                gap_count = 0;
                feed_q.delete(0);
            end
            else
            begin
                in_valid <= 1'b0;
                cfg_we   <= 1'b0;
                gap_count++;
            end
        end
    end

    // receiver: stalls drawn per beat, every field checked against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rx_stall = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pending_scaled.size() == 0)
                    report_mismatch($sformatf("unexpected beat sample %0d ch %0d",
                                              sample_out, channel_out));
                else
                begin
                    if (sample_out !== pending_scaled[0].sample)
                        report_mismatch($sformatf("ch %0d sample_out %0d, want %0d",
                                                  pending_scaled[0].channel, sample_out,
                                                  pending_scaled[0].sample));
                    if (channel_out !== pending_scaled[0].channel)
                        report_mismatch($sformatf("channel_out %0d, want %0d",
                                                  channel_out, pending_scaled[0].channel));
                    if (saturated !== pending_scaled[0].clipped)
                        report_mismatch($sformatf("ch %0d saturated %0b, want %0b",
                                                  pending_scaled[0].channel, saturated,
                                                  pending_scaled[0].clipped));
                    pending_scaled.delete(0);
                end
                results_seen++;
                if (results_seen % 150 == 0)
                    rx_calm = ($urandom_range(0, 2) == 0);
                rx_stall = draw_wait(rx_calm);
            end
            else if (rx_stall > 0)
                rx_stall--;
            out_ready <= (rx_stall == 0);
        end
    end

    // stimulus list, then wait for the block to drain
    initial
    begin : stimulus
        int          seg_len;
        int          n;
        logic [2:0]  ch;

        // directed: reset settings, threshold of 32768 so every beat passes through
        push_sample(16'sh7FFF, 3'd0);
        push_sample(16'sh8000, 3'd7);
        push_sample(16'sh0000, 3'd3);

        // plain 2:1 compression with instant attack
        push_drain();
        push_config(CFG_THRESHOLD, 17'd8192);
        push_config(CFG_SLOPE, 17'd2048);
        push_config(CFG_ATTACK, 17'd65536);
        push_config(CFG_RELEASE, 17'd100);
        push_sample(16'sh7FFF, 3'd1);
        push_sample(16'sh8000, 3'd1);
        push_sample(16'shFFFF, 3'd1);
        push_sample(16'sh0001, 3'd2);
        push_sample(16'sh0000, 3'd1);
        push_sample(16'sd12000, 3'd4);

        // zero threshold, steepest expansion, coefficients above one
        push_drain();
        push_config(CFG_THRESHOLD, 17'd0);
        push_config(CFG_SLOPE, 17'd65535);
        push_config(CFG_ATTACK, 17'd131071);
        push_config(CFG_RELEASE, 17'd131071);
        push_sample(16'sd100, 3'd5);
        push_sample(-16'sd100, 3'd5);
        push_sample(16'sh7FFF, 3'd6);
        push_sample(16'sh8000, 3'd6);

        // threshold above one, envelope frozen
        push_drain();
        push_config(CFG_THRESHOLD, 17'd65535);
        push_config(CFG_SLOPE, 17'd0);
        push_config(CFG_ATTACK, 17'd0);
        push_config(CFG_RELEASE, 17'd0);
        push_sample(16'sh7FFF, 3'd0);
        push_sample(16'sh8000, 3'd2);

        // smallest threshold with slope zero, gain inverts the envelope
        push_drain();
        push_config(CFG_THRESHOLD, 17'd1);
        push_config(CFG_ATTACK, 17'd65536);
        push_config(CFG_RELEASE, 17'd65535);
        push_sample(16'sh8000, 3'd4);
        push_sample(16'sh7FFF, 3'd4);
        push_sample(16'sd2, 3'd4);
        push_sample(-16'sd2, 3'd4);

        // random segments, each behind a drain and a fresh register set
        ch = 3'($urandom_range(0, CHANNELS - 1));
        while (sample_total < SAMPLE_ITEMS)
        begin
            sender_calm = ($urandom_range(0, 3) == 0);
            push_drain();
            push_config(CFG_THRESHOLD, {1'($urandom_range(0, 1)), pick_threshold()});
            push_config(CFG_SLOPE, {1'($urandom_range(0, 1)), pick_slope()});
            push_config(CFG_ATTACK, pick_coeff());
            push_config(CFG_RELEASE, pick_coeff());
            seg_len = $urandom_range(30, 150);
            for (n = 0; n < seg_len; n++)
            begin
                // runs on one channel let its envelope build up
                if ($urandom_range(0, 2) == 0)
                    ch = 3'($urandom_range(0, CHANNELS - 1));
                push_sample(pick_sample(), ch);
            end
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (feed_q.size() != 0 || in_valid)
            @(posedge clk);
        while (pending_scaled.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial
    begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl
rtl/ace_pkg.sv
rtl/audio_compressor_expander_core.sv
verif/audio_compressor_expander_core_test.sv
